@@ rtl/vpa_pkg.sv @@
// shared widths, event and action codes and control structs of the voice allocator
package vpa_pkg;

	localparam int NOTE_W      = 7;
	localparam int VEL_W       = 7;
	localparam int KIND_W      = 2;
	localparam int ACT_W       = 2;
	localparam int VOICE_OUT_W = 4;
	localparam int KEY_COUNT   = 128;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 32;

	// event kinds carried on the input tuser
	localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ALL_OFF  = 2'd2;

	// result actions
	localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_START   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

	// command to the active list cells
	typedef struct packed {
		logic ins;
		logic rem;
	} act_cmd_t;

	// update to the key table
	typedef struct packed {
		logic              set;
		logic              clr_press;
		logic              unlink;
		logic [NOTE_W-1:0] unlink_note;
	} key_upd_t;

endpackage

@@ rtl/poly_voice_allocator_core.sv @@
// Polyphonic voice allocator: maps note events onto synth voices, stealing the oldest.
//
// Input stream (s_axis): one beat per event. tuser carries the event kind (note on,
// note off, all notes off), tdata carries note and velocity.
// Output stream (m_axis): one or more result beats per event, tlast on the final one.
// A note on or note off gives exactly one beat; all notes off gives one beat per
// active voice, newest first, or a single empty beat when nothing is playing.
// Timing: an accepted event first goes through the key table lookup, then its first
// result is loaded into the output register once that is free; further all-off results
// follow one by one. s_axis_tready returns the cycle after the last result is
// loaded, while that result may still wait in the output register.
// The active list is a row of NUM_VOICES cells that shift together on an insert
// at the front or a removal anywhere; the free voices sit in a shifting stack.
// Reset empties the active list, fills the free stack with voice 0 on top and clears
// all key bits at once; there is no clearing pass.
// When m_axis_tready is low the sequencer holds its event until the output register
// frees up; no result is dropped.
module poly_voice_allocator_core
	import vpa_pkg::*;
#(
	parameter int NUM_VOICES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // note[6:0], velocity[13:7]
	input  logic [KIND_W-1:0]     s_axis_tuser,  // kind[1:0]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// action[1:0], voice[5:2], voice_note[12:6], voice_velocity[19:13],
	// reused[20], stolen[21], stolen_note[28:22]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast
);

	localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ALL
	} state_t;

	state_t                state_q;
	logic [KIND_W-1:0]     kind_q;
	logic [NOTE_W-1:0]     note_q;
	logic [VEL_W-1:0]      vel_q;
	logic                  out_valid_q;
	logic                  out_last_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [VW-1:0]     c_voice [NUM_VOICES+1];
	logic [NOTE_W-1:0] c_note  [NUM_VOICES+1];
	logic [NUM_VOICES:0] c_valid;
	logic [NUM_VOICES:0] found;

	act_cmd_t      cmd;
	key_upd_t      kupd;
	logic [VW-1:0] target;
	logic [VW-1:0] new_voice;
	logic [VW-1:0] set_voice;
	logic [VW-1:0] key_voice;
	logic [VW-1:0] free_top;
	logic          free_empty;
	logic          key_linked;
	logic          key_pressed;
	logic          push;
	logic          pop;
	logic          accept;

	logic slot_free, is_on, is_off, is_all, all_start, do_exec, do_all;
	logic steal, on_new, off_rel, load_out;

	logic [ACT_W-1:0]       res_action;
	logic [VOICE_OUT_W-1:0] res_voice;
	logic [NOTE_W-1:0]      res_vnote;
	logic [VEL_W-1:0]       res_vel;
	logic                   res_reused;
	logic                   res_stolen;
	logic [NOTE_W-1:0]      res_snote;
	logic                   res_last;
	logic [OUT_DATA_W-1:0]  res_data;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// entry past the last cell reads as empty
	assign c_voice[NUM_VOICES] = '0;
	assign c_note[NUM_VOICES]  = '0;
	assign c_valid[NUM_VOICES] = 1'b0;
	assign found[0]            = 1'b0;

	for (genvar i = 0; i < NUM_VOICES; i++) begin : g_cell
		logic [VW-1:0]     p_voice;
		logic [NOTE_W-1:0] p_note;
		logic              p_valid;
		if (i == 0) begin : g_front
			assign p_voice = new_voice;
			assign p_note  = note_q;
			assign p_valid = 1'b1;
		end else begin : g_inner
			assign p_voice = c_voice[i-1];
			assign p_note  = c_note[i-1];
			assign p_valid = c_valid[i-1];
		end
		vpa_cell #(
			.VW(VW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.target    (target),
			.prev_voice(p_voice),
			.prev_note (p_note),
			.prev_valid(p_valid),
			.next_voice(c_voice[i+1]),
			.next_note (c_note[i+1]),
			.next_valid(c_valid[i+1]),
			.found_in  (found[i]),
			.found_out (found[i+1]),
			.voice     (c_voice[i]),
			.note      (c_note[i]),
			.valid     (c_valid[i])
		);
	end

	vpa_free #(
		.NUM_VOICES(NUM_VOICES),
		.VW        (VW)
	) u_free (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.push_voice(target),
		.top_voice (free_top),
		.empty     (free_empty)
	);

	vpa_keys #(
		.VW(VW)
	) u_keys (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_note  (s_axis_tdata[NOTE_W-1:0]),
		.rd_voice (key_voice),
		.look_note(note_q),
		.linked   (key_linked),
		.pressed  (key_pressed),
		.upd      (kupd),
		.set_voice(set_voice)
	);

	always_comb begin
		slot_free = !out_valid_q || m_axis_tready;
		is_on     = (kind_q == KIND_NOTE_ON);
		is_off    = (kind_q == KIND_NOTE_OFF);
		is_all    = (kind_q == KIND_ALL_OFF);
		all_start = (state_q == ST_EXEC) && is_all && c_valid[0];
		do_exec   = (state_q == ST_EXEC) && slot_free && !all_start;
		do_all    = (state_q == ST_ALL) && slot_free;
		on_new    = is_on && !key_linked;
		// no free voice: the oldest cell drops off the end and its voice goes to the front
		steal     = on_new && free_empty;
		off_rel   = is_off && key_pressed && key_linked;
		new_voice = steal ? c_voice[NUM_VOICES-1] : free_top;
		set_voice = key_linked ? key_voice : new_voice;
		target    = (state_q == ST_ALL) ? c_voice[0] : key_voice;

		cmd.ins = do_exec && on_new;
		cmd.rem = (do_exec && off_rel) || do_all;
		push    = cmd.rem && found[NUM_VOICES];
		pop     = do_exec && on_new && !steal;

		kupd.set         = do_exec && is_on;
		kupd.clr_press   = do_exec && is_off;
		kupd.unlink      = (do_exec && steal) || push;
		kupd.unlink_note = steal ? c_note[NUM_VOICES-1] :
			((state_q == ST_ALL) ? c_note[0] : note_q);

		res_action = ACT_NONE;
		res_voice  = '0;
		res_vnote  = '0;
		res_vel    = '0;
		res_reused = 1'b0;
		res_stolen = 1'b0;
		res_snote  = '0;
		res_last   = 1'b1;
		if (state_q == ST_ALL) begin
			res_action = ACT_RELEASE;
			res_voice  = VOICE_OUT_W'(c_voice[0]);
			res_vnote  = c_note[0];
			res_last   = !c_valid[1];
		end else if (is_on) begin
			res_action = ACT_START;
			res_voice  = VOICE_OUT_W'(set_voice);
			res_vnote  = note_q;
			res_vel    = vel_q;
			res_reused = key_linked;
			res_stolen = steal;
			res_snote  = steal ? c_note[NUM_VOICES-1] : '0;
		end else if (off_rel) begin
			res_action = ACT_RELEASE;
			res_voice  = VOICE_OUT_W'(key_voice);
			res_vnote  = note_q;
		end
		res_data = {3'b000, res_snote, res_stolen, res_reused, res_vel, res_vnote,
			res_voice, res_action};
		load_out = do_exec || do_all;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= '0;
			note_q      <= '0;
			vel_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_last_q  <= res_last;
				out_data_q  <= res_data;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q  <= s_axis_tuser;
						note_q  <= s_axis_tdata[NOTE_W-1:0];
						vel_q   <= s_axis_tdata[NOTE_W+VEL_W-1:NOTE_W];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (all_start) begin
						state_q <= ST_ALL;
					end else if (do_exec) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ALL: begin
					if (do_all && res_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/vpa_cell.sv @@
// one entry of the recency-ordered active voice list
module vpa_cell
	import vpa_pkg::*;
#(
	parameter int VW = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  act_cmd_t          cmd,
	input  logic [VW-1:0]     target,
	input  logic [VW-1:0]     prev_voice,
	input  logic [NOTE_W-1:0] prev_note,
	input  logic              prev_valid,
	input  logic [VW-1:0]     next_voice,
	input  logic [NOTE_W-1:0] next_note,
	input  logic              next_valid,
	input  logic              found_in,
	output logic              found_out,
	output logic [VW-1:0]     voice,
	output logic [NOTE_W-1:0] note,
	output logic              valid
);

	logic [VW-1:0]     voice_q;
	logic [NOTE_W-1:0] note_q;
	logic              valid_q;
	logic              take_next;

	// once the removed voice is seen, this cell and all behind it pull from the next one
	assign found_out = found_in | (valid_q && (voice_q == target));
	assign take_next = cmd.rem && found_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_next) begin
			valid_q <= next_valid;
		end else if (cmd.ins) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_next) begin
			voice_q <= next_voice;
			note_q  <= next_note;
		end else if (cmd.ins) begin
			voice_q <= prev_voice;
			note_q  <= prev_note;
		end
	end

	assign voice = voice_q;
	assign note  = note_q;
	assign valid = valid_q;

endmodule

@@ rtl/vpa_free.sv @@
// free voice stack as a shifting row of registers, top at entry zero
module vpa_free
	import vpa_pkg::*;
#(
	parameter int NUM_VOICES = 16,
	parameter int VW         = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic          pop,
	input  logic [VW-1:0] push_voice,
	output logic [VW-1:0] top_voice,
	output logic          empty
);

	localparam int CW = $clog2(NUM_VOICES + 1);

	logic [VW-1:0] stk_q [NUM_VOICES];
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign empty     = (count_q == '0);
	assign top_voice = stk_q[0];
	assign do_push   = push && (count_q != CW'(NUM_VOICES));
	assign do_pop    = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(NUM_VOICES);
			for (int i = 0; i < NUM_VOICES; i++) begin
				stk_q[i] <= VW'(i);
			end
		end else if (do_push) begin
			count_q  <= count_q + 1'b1;
			stk_q[0] <= push_voice;
			for (int i = 1; i < NUM_VOICES; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end else if (do_pop) begin
			count_q <= count_q - 1'b1;
			for (int i = 0; i < NUM_VOICES - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
			stk_q[NUM_VOICES-1] <= '0;
		end
	end

endmodule

@@ rtl/vpa_keys.sv @@
// per-key table: owning voice in a memory, linked and pressed bits in flops
module vpa_keys
	import vpa_pkg::*;
#(
	parameter int VW = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [NOTE_W-1:0] rd_note,
	output logic [VW-1:0]     rd_voice,
	input  logic [NOTE_W-1:0] look_note,
	output logic              linked,
	output logic              pressed,
	input  key_upd_t          upd,
	input  logic [VW-1:0]     set_voice
);

	logic [VW-1:0]        voice_mem [KEY_COUNT];
	logic [VW-1:0]        rd_voice_q;
	logic [KEY_COUNT-1:0] linked_q;
	logic [KEY_COUNT-1:0] linked_d;
	logic [KEY_COUNT-1:0] pressed_q;

	always_ff @(posedge clk) begin
		if (upd.set) begin
			voice_mem[look_note] <= set_voice;
		end
		if (rd_en) begin
			rd_voice_q <= voice_mem[rd_note];
		end
	end

	// a new link on the looked-up key wins over an unlink in the same cycle
	always_comb begin
		linked_d = linked_q;
		if (upd.unlink) begin
			linked_d[upd.unlink_note] = 1'b0;
		end
		if (upd.set) begin
			linked_d[look_note] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linked_q  <= '0;
			pressed_q <= '0;
		end else begin
			linked_q <= linked_d;
			if (upd.set) begin
				pressed_q[look_note] <= 1'b1;
			end else if (upd.clr_press) begin
				pressed_q[look_note] <= 1'b0;
			end
		end
	end

	assign rd_voice = rd_voice_q;
	assign linked   = linked_q[look_note];
	assign pressed  = pressed_q[look_note];

endmodule

@@ rtl/vpa_checker.sv @@
// port-level checks of the voice allocator, bound to the top level
module vpa_checker
	import vpa_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tlast
);

	// an accepted event keeps the input closed during its key table lookup
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after an accepted event");

	// while waiting for an event, a pending result is the final one of its event
	a_idle_pending_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
		else $error("non-final result pending while input is ready");

	// an empty result always closes its event
	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] == ACT_NONE) |-> m_axis_tlast)
		else $error("empty result without tlast");

	// a release carries no velocity, reuse or steal information
	a_release_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] == ACT_RELEASE) |->
		(m_axis_tdata[28:13] == '0))
		else $error("release beat carries start fields");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast))
		else $error("stalled output beat changed");

endmodule

bind poly_voice_allocator_core vpa_checker u_vpa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);

@@ dv/poly_voice_allocator_core_tb.sv @@
// self-checking testbench of the voice allocator core with its own allocation predictor
module poly_voice_allocator_core_tb;
	import vpa_pkg::*;

	localparam int NV = 16;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [2:0]             pad;
		logic [NOTE_W-1:0]      stolen_note;
		logic                   stolen;
		logic                   reused;
		logic [VEL_W-1:0]       velocity;
		logic [NOTE_W-1:0]      note;
		logic [VOICE_OUT_W-1:0] voice;
		logic [ACT_W-1:0]       action;
	} beat_t;

	typedef struct packed {
		beat_t data;
		logic  last;
	} voice_beat_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  velocity;
	} midi_event_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [KIND_W-1:0]     s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	poly_voice_allocator_core #(
		.NUM_VOICES(NV)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	// allocator state as the predictor sees it
	logic [VOICE_OUT_W-1:0] key_voice [KEY_COUNT];
	logic                   key_linked [KEY_COUNT];
	logic                   key_pressed [KEY_COUNT];
	logic [VOICE_OUT_W-1:0] active_list [NV];
	int                     active_cnt;
	logic [VOICE_OUT_W-1:0] free_voices [NV];
	int                     free_cnt;
	logic [NOTE_W-1:0]      voice_note_of [NV];

	midi_event_t midi_events[$];
	voice_beat_t due_voice_beats[$];
	voice_beat_t event_beats[$];

	logic in_fire;
	int   accepted_items;
	int   fails;
	int   cycle_count;
	int   send_gap;
	bit   send_burst;
	int   stall_left;
	bit   recv_burst;
	int   hold_left;
	bit   hold_done;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic string fmt_beat(voice_beat_t b);
		return $sformatf({"act=%0d voice=%0d note=%0d vel=%0d reused=%0d stolen=%0d",
			" snote=%0d pad=%0d last=%0d"},
			b.data.action, b.data.voice, b.data.note, b.data.velocity, b.data.reused,
			b.data.stolen, b.data.stolen_note, b.data.pad, b.last);
	endfunction

	function automatic void reset_model();
		for (int i = 0; i < KEY_COUNT; i++) begin
			key_voice[i]   = '0;
			key_linked[i]  = 1'b0;
			key_pressed[i] = 1'b0;
		end
		for (int i = 0; i < NV; i++) begin
			active_list[i]   = '0;
			voice_note_of[i] = '0;
			free_voices[i]   = VOICE_OUT_W'(NV - 1 - i);
		end
		active_cnt = 0;
		free_cnt   = NV;
	endfunction

	function automatic void push_beat(logic [ACT_W-1:0] action, logic [VOICE_OUT_W-1:0] v,
			logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel, logic reused, logic stolen,
			logic [NOTE_W-1:0] snote);
		voice_beat_t b;
		b.data.pad         = '0;
		b.data.action      = action;
		b.data.voice       = v;
		b.data.note        = note;
		b.data.velocity    = vel;
		b.data.reused      = reused;
		b.data.stolen      = stolen;
		b.data.stolen_note = snote;
		b.last             = 1'b0;
		event_beats.insert(event_beats.size(), b);
	endfunction

	// take a voice out of the active list, return it to the free stack and unlink its key
	function automatic void free_voice(logic [VOICE_OUT_W-1:0] v);
		int pos;
		pos = active_cnt;
		for (int i = 0; i < active_cnt; i++) begin
			if (active_list[i] == v) begin
				pos = i;
				break;
			end
		end
		if (pos < active_cnt) begin
			for (int i = pos; i + 1 < active_cnt; i++)
				active_list[i] = active_list[i+1];
			active_cnt--;
			if (free_cnt < NV) begin
				free_voices[free_cnt] = v;
				free_cnt++;
			end
			key_linked[voice_note_of[v]] = 1'b0;
		end
	endfunction

	function automatic void allocate_event(logic [KIND_W-1:0] kind, logic [NOTE_W-1:0] note,
			logic [VEL_W-1:0] vel);
		logic [VOICE_OUT_W-1:0] v;
		logic [VOICE_OUT_W-1:0] oldest;
		logic                   reused;
		logic                   stolen;
		logic [NOTE_W-1:0]      snote;
		logic [NOTE_W-1:0]      vn;
		int                     prev_cnt;
		voice_beat_t            b;
		event_beats.delete();
		reused = 1'b0;
		stolen = 1'b0;
		snote  = '0;
		case (kind)
			KIND_NOTE_ON: begin
				if (key_linked[note]) begin
					v = key_voice[note];
					reused = 1'b1;
				end else begin
					if (free_cnt == 0 && active_cnt > 0) begin
						oldest = active_list[active_cnt-1];
						stolen = 1'b1;
						snote  = voice_note_of[oldest];
						free_voice(oldest);
					end
					if (free_cnt == 0) begin
						v = '0;
					end else begin
						free_cnt--;
						v = free_voices[free_cnt];
					end
					if (active_cnt < NV) begin
						for (int i = active_cnt; i > 0; i--)
							active_list[i] = active_list[i-1];
						active_list[0] = v;
						active_cnt++;
					end
				end
				voice_note_of[v] = note;
				key_voice[note] = v;
				key_linked[note] = 1'b1;
				key_pressed[note] = 1'b1;
				push_beat(ACT_START, v, note, vel, reused, stolen, snote);
			end
			KIND_NOTE_OFF: begin
				if (key_pressed[note] && key_linked[note]) begin
					v  = key_voice[note];
					vn = voice_note_of[v];
					free_voice(v);
					push_beat(ACT_RELEASE, v, vn, '0, 1'b0, 1'b0, '0);
				end
				key_pressed[note] = 1'b0;
			end
			KIND_ALL_OFF: begin
				while (active_cnt > 0) begin
					v        = active_list[0];
					vn       = voice_note_of[v];
					prev_cnt = active_cnt;
					free_voice(v);
					push_beat(ACT_RELEASE, v, vn, '0, 1'b0, 1'b0, '0);
					if (active_cnt == prev_cnt)
						break;
				end
			end
			default: ;
		endcase
		if (event_beats.size() == 0)
			push_beat(ACT_NONE, '0, '0, '0, 1'b0, 1'b0, '0);
		b = event_beats[event_beats.size()-1];
		b.last = 1'b1;
		event_beats[event_beats.size()-1] = b;
		foreach (event_beats[i])
			due_voice_beats.insert(due_voice_beats.size(), event_beats[i]);
	endfunction

	function automatic void add_event(logic [KIND_W-1:0] kind, logic [NOTE_W-1:0] note,
			logic [VEL_W-1:0] vel);
		midi_event_t e;
		e.kind     = kind;
		e.note     = note;
		e.velocity = vel;
		midi_events.insert(midi_events.size(), e);
	endfunction

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** poly_voice_allocator_core: FAILED **");
			$finish;
		end
	end

	// sample both handshakes, update the predictor and check result beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fire <= 1'b0;
			reset_model();
		end else begin
			in_fire <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				allocate_event(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[13:7]);
				accepted_items++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				voice_beat_t got;
				voice_beat_t want;
				got.data = beat_t'(m_axis_tdata);
				got.last = m_axis_tlast;
				if (due_voice_beats.size() == 0) begin
					$display("%0t: result beat with nothing expected: %s", $time,
						fmt_beat(got));
					fails++;
				end else begin
					want = due_voice_beats[0];
					due_voice_beats.delete(0);
					if (got !== want) begin
						$display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
							fmt_beat(want), fmt_beat(got));
						fails++;
					end
				end
			end
		end
	end

	// sender: hold each event until taken, then maybe leave a gap
	always @(negedge clk) begin
		if (!arst_n) begin
			send_gap = $urandom_range(0, 3);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			if (in_fire) begin
				midi_events.delete(0);
				send_gap = send_burst ? 0 : pick_gap();
				if ($urandom_range(0, 19) == 0)
					send_burst = !send_burst;
			end
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (midi_events.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tuser  <= midi_events[0].kind;
				s_axis_tdata  <= {2'b00, midi_events[0].velocity, midi_events[0].note};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (!hold_done && accepted_items >= 60) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if ($urandom_range(0, 49) == 0)
					recv_burst = !recv_burst;
				if (!recv_burst && $urandom_range(0, 3) == 0) begin
					stall_left = pick_gap();
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	initial begin
		int            sel;
		int            pool_base;
		logic [NOTE_W-1:0] key;
		logic [KIND_W-1:0] kind;

		arst_n = 1'b0;

		// directed: empty cases, extremes, retrigger, release, steal, full all-off
		add_event(KIND_ALL_OFF, 7'd0, 7'd0);
		add_event(KIND_NOTE_OFF, 7'd60, 7'd0);
		add_event(KIND_UNUSED, 7'd127, 7'd127);
		add_event(KIND_NOTE_ON, 7'd0, 7'd0);
		add_event(KIND_NOTE_ON, 7'd127, 7'd127);
		add_event(KIND_NOTE_ON, 7'd0, 7'd64);
		add_event(KIND_NOTE_OFF, 7'd127, 7'd127);
		add_event(KIND_NOTE_OFF, 7'd127, 7'd0);
		for (int i = 0; i < 16; i++)
			add_event(KIND_NOTE_ON, NOTE_W'(100 + i), VEL_W'($urandom_range(0, 127)));
		// key 0 was stolen: pressed but no longer linked
		add_event(KIND_NOTE_OFF, 7'd0, 7'd0);
		add_event(KIND_ALL_OFF, 7'd0, 7'd0);

		// random: mostly a moving pool of keys so offs and retriggers land
		pool_base = $urandom_range(0, 104);
		for (int n = 0; n < 194; n++) begin
			if ($urandom_range(0, 29) == 0)
				pool_base = $urandom_range(0, 104);
			if ($urandom_range(0, 9) < 7)
				key = NOTE_W'(pool_base + $urandom_range(0, 23));
			else
				key = NOTE_W'($urandom_range(0, 127));
			sel = $urandom_range(0, 99);
			if (sel < 52)
				kind = KIND_NOTE_ON;
			else if (sel < 90)
				kind = KIND_NOTE_OFF;
			else if (sel < 96)
				kind = KIND_ALL_OFF;
			else
				kind = KIND_UNUSED;
			add_event(kind, key, VEL_W'($urandom_range(0, 127)));
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (midi_events.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (due_voice_beats.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fails == 0)
			$display("** poly_voice_allocator_core: PASSED **");
		else
			$display("** poly_voice_allocator_core: FAILED **");
		$finish;
	end

endmodule
